// ===== rtl/core/ham_pkg.sv =====
// Shared operation and status codes for the Hopfield associative memory.
`timescale 1ns / 1ps
`default_nettype none

package ham_pkg;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_TRAIN  = 2'd0;
	localparam op_t OP_RECALL = 2'd1;
	localparam op_t OP_CLEAR  = 2'd2;

	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_LIMIT = 2'd1;
	localparam status_t STATUS_CAP   = 2'd2;

	localparam int SAMPLE_BITS = 7;
	localparam int COUNT_BITS  = 8;
	localparam logic [SAMPLE_BITS-1:0] SAMPLES_RESET = 7'd9;
	localparam int LANES = 8;

endpackage

`default_nettype wire

// ===== rtl/core/hopfield_associative_memory.sv =====
// Hopfield associative memory with Hebbian training and sequential recall.
`timescale 1ns / 1ps
`default_nettype none

// The weight matrix lives in a memory with one read port and one write port,
// one row of NEURONS weights per neuron and a registered read; rows that were
// never written since reset or a clear read as zero through per-row valid
// flags. A train request reads, updates and writes back one row per cycle.
// A recall request runs S sweeps (at least one, at most MAX_SWEEPS); in each
// sweep each neuron reads its row once and accumulates eight weights per
// cycle. One request is in work at a time; a new request is taken while the
// previous result still waits at the output.
module hopfield_associative_memory #(
	parameter int NEURONS     = 64,
	parameter int WEIGHT_BITS = 8,
	parameter int MAX_SWEEPS  = 32
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_wr_en,
	input  wire  [ham_pkg::SAMPLE_BITS-1:0]       cfg_wr_data,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  ham_pkg::op_t                    operation,
	input  wire  [63:0]                           pattern,
	input  wire                                   enforce_limit,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output ham_pkg::status_t                      status,
	output logic [63:0]                           recalled
);

	import ham_pkg::*;

	localparam int WB      = WEIGHT_BITS;
	localparam int ROW_W   = NEURONS * WB;
	localparam int IDX_W   = $clog2(NEURONS);
	localparam int CHUNKS  = (NEURONS + LANES - 1) / LANES;
	localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int PAD_N   = CHUNKS * LANES;
	localparam int SUM_W   = WB + IDX_W + 2;
	localparam int SWEEP_W = (MAX_SWEEPS > 1) ? $clog2(MAX_SWEEPS) : 1;

	localparam logic signed [WB-1:0] W_MAX = {1'b0, {(WB-1){1'b1}}};
	localparam logic signed [WB-1:0] W_MIN = {1'b1, {(WB-1){1'b0}}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_TRAIN,
		S_READ,
		S_SUM,
		S_DECIDE,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [ROW_W-1:0]        weight_mem_q [NEURONS];
	logic [ROW_W-1:0]        rdata_s1;
	logic                    rvalid_s1;
	logic [NEURONS-1:0]      row_valid_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        idx_s1;
	logic                    trn_valid_s1;
	logic                    rd_done_q;
	logic [NEURONS-1:0]      pat_q;
	logic [NEURONS-1:0]      nv_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [SAMPLE_BITS-1:0]  max_q;
	logic [CHUNK_W-1:0]      chunk_q;
	logic signed [SUM_W-1:0] acc_q;
	logic [SWEEP_W-1:0]      sweep_q;
	logic                    changed_q;
	status_t                 res_status_q;
	logic                    res_recall_q;
	logic                    out_valid_q;
	status_t                 status_q;
	logic [63:0]             recalled_q;

	logic                       mem_re;
	logic                       mem_we;
	logic [ROW_W-1:0]           row_eff;
	logic [ROW_W-1:0]           row_next;
	logic [PAD_N*WB-1:0]        row_pad;
	logic [PAD_N-1:0]           nv_pad;
	logic [LANES*WB-1:0]        chunk_w;
	logic [LANES-1:0]           chunk_s;
	logic signed [SUM_W-1:0]    chunk_sum;
	logic                       new_bit;
	logic                       limit_hit;

	function automatic logic [WB-1:0] sat_step(input logic signed [WB-1:0] w, input logic up);
		logic [WB-1:0] r;
		if (up) begin
			r = (w == W_MAX) ? w : w + WB'(1);
		end else begin
			r = (w == W_MIN) ? w : w - WB'(1);
		end
		return r;
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign recalled  = recalled_q;

	assign mem_re = ((state_q == S_TRAIN) && !rd_done_q) || (state_q == S_READ);
	assign mem_we = trn_valid_s1;
	assign row_eff = rvalid_s1 ? rdata_s1 : '0;

	always_comb begin
		for (int j = 0; j < NEURONS; j++) begin
			if (idx_s1 == IDX_W'(j)) begin
				row_next[j*WB +: WB] = '0;
			end else begin
				row_next[j*WB +: WB] = sat_step(row_eff[j*WB +: WB], pat_q[idx_s1] == pat_q[j]);
			end
		end
	end

	assign row_pad = (PAD_N*WB)'(row_eff);
	assign nv_pad  = PAD_N'(nv_q);
	assign chunk_w = row_pad[chunk_q*LANES*WB +: LANES*WB];
	assign chunk_s = nv_pad[chunk_q*LANES +: LANES];

	always_comb begin
		logic signed [SUM_W-1:0] term;
		chunk_sum = '0;
		for (int k = 0; k < LANES; k++) begin
			term = SUM_W'($signed(chunk_w[k*WB +: WB]));
			chunk_sum = chunk_s[k] ? chunk_sum + term : chunk_sum - term;
		end
	end

	assign new_bit   = !acc_q[SUM_W-1];
	assign limit_hit = enforce_limit &&
		({1'b0, count_q} + (COUNT_BITS+1)'(1) > (COUNT_BITS+1)'(max_q));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			weight_mem_q[idx_s1] <= row_next;
		end
		if (mem_re) begin
			rdata_s1  <= weight_mem_q[idx_q];
			rvalid_s1 <= row_valid_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			row_valid_q  <= '0;
			count_q      <= '0;
			max_q        <= SAMPLES_RESET;
			trn_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
			rd_done_q    <= 1'b0;
			idx_q        <= '0;
			idx_s1       <= '0;
			nv_q         <= '0;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			if ((state_q == S_DONE) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			trn_valid_s1 <= (state_q == S_TRAIN) && !rd_done_q;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pat_q        <= pattern[NEURONS-1:0];
						idx_q        <= '0;
						rd_done_q    <= 1'b0;
						res_status_q <= ((operation == OP_TRAIN) && limit_hit) ?
							STATUS_LIMIT : STATUS_OK;
						res_recall_q <= 1'b0;
						case (operation)
							OP_TRAIN: begin
								if (limit_hit) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_TRAIN;
								end
							end
							OP_RECALL: begin
								nv_q      <= pattern[NEURONS-1:0];
								sweep_q   <= '0;
								changed_q <= 1'b0;
								state_q   <= S_READ;
							end
							OP_CLEAR: begin
								row_valid_q <= '0;
								count_q     <= '0;
								state_q     <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_TRAIN: begin
					if (!rd_done_q) begin
						idx_s1 <= idx_q;
						if (idx_q == IDX_W'(NEURONS-1)) begin
							rd_done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
					if (trn_valid_s1) begin
						row_valid_q[idx_s1] <= 1'b1;
						if (idx_s1 == IDX_W'(NEURONS-1)) begin
							if (count_q != '1) begin
								count_q <= count_q + COUNT_BITS'(1);
							end
							state_q <= S_DONE;
						end
					end
				end
				S_READ: begin
					chunk_q <= '0;
					acc_q   <= '0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q <= acc_q + chunk_sum;
					if (chunk_q == CHUNK_W'(CHUNKS-1)) begin
						state_q <= S_DECIDE;
					end else begin
						chunk_q <= chunk_q + CHUNK_W'(1);
					end
				end
				S_DECIDE: begin
					logic changed_now;
					changed_now = changed_q || (new_bit != nv_q[idx_q]);
					nv_q[idx_q] <= new_bit;
					if (idx_q == IDX_W'(NEURONS-1)) begin
						idx_q <= '0;
						if (!changed_now) begin
							res_recall_q <= 1'b1;
							state_q      <= S_DONE;
						end else if (sweep_q == SWEEP_W'(MAX_SWEEPS-1)) begin
							res_recall_q <= 1'b1;
							res_status_q <= STATUS_CAP;
							state_q      <= S_DONE;
						end else begin
							sweep_q   <= sweep_q + SWEEP_W'(1);
							changed_q <= 1'b0;
							state_q   <= S_READ;
						end
					end else begin
						changed_q <= changed_now;
						idx_q     <= idx_q + IDX_W'(1);
						state_q   <= S_READ;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						status_q    <= res_status_q;
						recalled_q  <= res_recall_q ? 64'(nv_q) : 64'd0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== test/hopfield_associative_memory_checker.sv =====
// Checker that predicts every Hopfield memory result and compares it with the block's output.
`timescale 1ns / 1ps

module hopfield_associative_memory_checker #(
	parameter int NEURONS     = 64,
	parameter int WEIGHT_BITS = 8,
	parameter int MAX_SWEEPS  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [ham_pkg::SAMPLE_BITS-1:0] cfg_wr_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  ham_pkg::op_t                    operation,
	input  logic [63:0]                     pattern,
	input  logic                            enforce_limit,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  ham_pkg::status_t                status,
	input  logic [63:0]                     recalled,
	output int                              mismatches,
	output int                              outstanding
);
	import ham_pkg::*;

	localparam int WEIGHT_HIGH = (1 << (WEIGHT_BITS - 1)) - 1;
	localparam int WEIGHT_LOW  = -WEIGHT_HIGH - 1;
	localparam logic [63:0] NEURON_MASK = (64'd1 << NEURONS) - 64'd1;

	typedef struct packed {
		status_t     status;
		logic [63:0] recalled;
	} ham_result_t;

	int                     weights [NEURONS][NEURONS];
	logic [63:0]            neurons;
	int                     trained;
	logic [SAMPLE_BITS-1:0] sample_limit;
	ham_result_t            awaited_results [$];

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic void zero_weights();
		for (int i = 0; i < NEURONS; i++)
			for (int j = 0; j < NEURONS; j++)
				weights[i][j] = 0;
	endfunction

	function automatic void hebbian_update(logic [63:0] pat);
		int w;
		for (int i = 0; i < NEURONS; i++) begin
			for (int j = 0; j < NEURONS; j++) begin
				if (i == j) begin
					weights[i][j] = 0;
				end else begin
					w = weights[i][j] + ((pat[i] == pat[j]) ? 1 : -1);
					if (w > WEIGHT_HIGH)
						w = WEIGHT_HIGH;
					if (w < WEIGHT_LOW)
						w = WEIGHT_LOW;
					weights[i][j] = w;
				end
			end
		end
		if (trained < 255)
			trained++;
	endfunction

	// Returns 1 when the last allowed sweep still flipped a neuron.
	function automatic logic run_recall(logic [63:0] pat);
		int   sum;
		logic changed;
		logic next_state;
		neurons = pat & NEURON_MASK;
		for (int s = 0; s < MAX_SWEEPS; s++) begin
			changed = 1'b0;
			for (int i = 0; i < NEURONS; i++) begin
				sum = 0;
				for (int j = 0; j < NEURONS; j++)
					sum += neurons[j] ? weights[i][j] : -weights[i][j];
				next_state = (sum >= 0);
				if (next_state != neurons[i]) begin
					neurons[i] = next_state;
					changed = 1'b1;
				end
			end
			if (!changed)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic ham_result_t apply_request(op_t op, logic [63:0] pat, logic enforce);
		ham_result_t r;
		r.status = STATUS_OK;
		r.recalled = '0;
		case (op)
			OP_TRAIN: begin
				if (enforce && trained + 1 > int'(sample_limit))
					r.status = STATUS_LIMIT;
				else
					hebbian_update(pat);
			end
			OP_RECALL: begin
				if (run_recall(pat))
					r.status = STATUS_CAP;
				r.recalled = neurons & NEURON_MASK;
			end
			OP_CLEAR: begin
				zero_weights();
				trained = 0;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		ham_result_t want;
		if (!arst_n) begin
			zero_weights();
			neurons = '0;
			trained = 0;
			sample_limit = SAMPLES_RESET;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with no request waiting, recalled", recalled, '0);
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status)
						report_mismatch("status", 64'(status), 64'(want.status));
					if (recalled !== want.recalled)
						report_mismatch("recalled", recalled, want.recalled);
				end
			end
			if (cfg_wr_en)
				sample_limit = cfg_wr_data;
			if (in_valid && !in_stall)
				awaited_results.push_back(apply_request(operation, pattern, enforce_limit));
			outstanding <= awaited_results.size();
		end
	end

endmodule

// ===== test/hopfield_associative_memory_tb.sv =====
// Testbench top that drives requests and sample limits into the Hopfield memory and gives the verdict.
`timescale 1ns / 1ps

module hopfield_associative_memory_tb;
	import ham_pkg::*;

	localparam op_t OP_UNUSED   = 2'd3;
	localparam int ITEM_TARGET  = 1900;
	localparam int CALM_ITEMS   = 150;
	localparam int HOLD_CYCLES  = 600;
	localparam int SAT_TRAINS   = 270;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [SAMPLE_BITS-1:0] cfg_wr_data;
	logic                   in_valid;
	logic                   in_stall;
	op_t                    operation;
	logic [63:0]            pattern;
	logic                   enforce_limit;
	logic                   out_valid;
	logic                   out_stall;
	status_t                status;
	logic [63:0]            recalled;
	int                     mismatches;
	int                     outstanding;
	int                     requests_sent = 0;
	int                     hold_asked = 0;
	logic                   calm = 1'b0;

	hopfield_associative_memory dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.pattern      (pattern),
		.enforce_limit(enforce_limit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.recalled     (recalled)
	);

	hopfield_associative_memory_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.pattern      (pattern),
		.enforce_limit(enforce_limit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.recalled     (recalled),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000_000;
		$display("hopfield_associative_memory_tb: errors");
		$finish;
	end

	function automatic logic [63:0] random_pattern();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] flip_bits(logic [63:0] pat, int count);
		logic [63:0] r;
		r = pat;
		repeat (count) r[$urandom_range(0, 63)] ^= 1'b1;
		return r;
	endfunction

	task automatic send_request(op_t op, logic [63:0] pat, logic enforce);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pattern <= pat;
		enforce_limit <= enforce;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(logic [SAMPLE_BITS-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Store a few patterns, then try to recover them from corrupted copies, with retrains and random requests mixed in.
	task automatic store_and_recall();
		logic [63:0] stored [6];
		int          count;
		int          roll;
		int          k;
		settle();
		case ($urandom_range(0, 5))
			0: write_limit('0);
			1: write_limit(SAMPLE_BITS'(1));
			2: write_limit(SAMPLE_BITS'(64));
			3: write_limit('1);
			4: write_limit(SAMPLE_BITS'($urandom_range(0, 127)));
			default: ;
		endcase
		if ($urandom_range(0, 4) != 0)
			send_request(OP_CLEAR, random_pattern(), 1'($urandom_range(0, 1)));
		count = $urandom_range(1, 6);
		for (k = 0; k < count; k++) begin
			stored[k] = random_pattern();
			send_request(OP_TRAIN, stored[k], $urandom_range(0, 2) != 0);
		end
		repeat ($urandom_range(3, 8)) begin
			roll = $urandom_range(0, 9);
			if (roll < 5)
				send_request(OP_RECALL,
					flip_bits(stored[$urandom_range(0, count - 1)], $urandom_range(0, 10)),
					1'($urandom_range(0, 1)));
			else if (roll < 7)
				send_request(OP_TRAIN, stored[$urandom_range(0, count - 1)],
					1'($urandom_range(0, 1)));
			else
				send_request(op_t'($urandom_range(0, 3)), random_pattern(),
					1'($urandom_range(0, 1)));
		end
	endtask

	initial begin : output_side
		int hold_done;
		int n;
		hold_done = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_done) begin
				hold_done = hold_asked;
				out_stall <= 1'b1;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 11);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm) begin
				n = $urandom_range(1, 30);
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin : input_side
		logic [63:0] pat;
		logic [63:0] anchor;
		logic        saturated;
		int          k;
		saturated = 1'b0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		operation <= OP_TRAIN;
		pattern <= '0;
		enforce_limit <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With all weights zero every sum ties, so every neuron turns active.
		send_request(OP_RECALL, '0, 1'b0);
		send_request(OP_UNUSED, '1, 1'b1);
		// The tenth enforced train goes past the sample limit that reset leaves.
		for (k = 0; k < 10; k++) begin
			case (k)
				0: pat = '1;
				1: pat = '0;
				2: pat = {32{2'b10}};
				3: pat = {32{2'b01}};
				default: pat = random_pattern();
			endcase
			send_request(OP_TRAIN, pat, 1'b1);
		end
		send_request(OP_TRAIN, 64'hFFFF_FFFF_0000_0000, 1'b0);
		send_request(OP_RECALL, '1, 1'b1);
		send_request(OP_RECALL, random_pattern(), 1'b0);
		send_request(OP_CLEAR, '1, 1'b1);
		send_request(OP_RECALL, 64'h8000_0000_0000_0001, 1'b0);
		settle();
		write_limit('0);
		send_request(OP_TRAIN, '1, 1'b1);
		send_request(OP_TRAIN, {32{2'b10}}, 1'b0);
		send_request(OP_RECALL, {32{2'b01}}, 1'b0);
		settle();
		write_limit('1);
		send_request(OP_TRAIN, '1, 1'b1);
		send_request(OP_RECALL, '0, 1'b0);

		// The output is held off long enough for the block to back up its input.
		settle();
		hold_asked <= hold_asked + 1;
		for (k = 0; k < 12; k++)
			send_request(OP_TRAIN, random_pattern(), 1'b0);

		while (requests_sent < ITEM_TARGET - CALM_ITEMS) begin
			if (!saturated && requests_sent > 700) begin
				// Training one pattern many times drives weights to both rails.
				saturated = 1'b1;
				settle();
				write_limit('1);
				anchor = random_pattern();
				send_request(OP_CLEAR, anchor, 1'b0);
				for (k = 0; k < SAT_TRAINS; k++) begin
					if ($urandom_range(0, 14) == 0)
						send_request(OP_RECALL, flip_bits(anchor, $urandom_range(1, 16)),
							1'($urandom_range(0, 1)));
					else
						send_request(OP_TRAIN, anchor, $urandom_range(0, 7) == 0);
				end
			end else begin
				store_and_recall();
			end
		end

		calm <= 1'b1;
		while (requests_sent < ITEM_TARGET)
			store_and_recall();
		settle();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("hopfield_associative_memory_tb: clean");
		else
			$display("hopfield_associative_memory_tb: errors");
		$finish;
	end

endmodule
